@@ sv/dfiir_pkg.sv @@
`default_nettype none

package dfiir_pkg;

    // input item kinds (s_tuser)
    localparam logic [1:0] OP_PROCESS = 2'd0;
    localparam logic [1:0] OP_COEF_WR = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    // configuration register indexes
    localparam logic REG_FILTER_ORDER = 1'b0;
    localparam logic REG_OUTPUT_GAIN  = 1'b1;

    localparam int ORDER_W  = 6;
    localparam int GAIN_W   = 31;
    localparam int CFG_W    = 31;
    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int CIDX_W   = 5;
    localparam int OP_W     = 2;

    // s_tdata layout, lowest bit first
    localparam int SAMPLE_LSB = 0;
    localparam int CIDX_LSB   = SAMPLE_LSB + SAMPLE_W;
    localparam int FF_LSB     = CIDX_LSB + CIDX_W;
    localparam int FB_LSB     = FF_LSB + COEF_W;
    localparam int S_TDATA_W  = 96;
    localparam int M_TDATA_W  = 24;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd1;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 31'd16777216;

    // saturation rails
    localparam logic [COEF_W-1:0]   STORED_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0]   STORED_MIN = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] OUT_MAX    = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] OUT_MIN    = 24'h80_0000;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RUN   = 6'b000010,
        S_SUM   = 6'b000100,
        S_SCALE = 6'b001000,
        S_GAIN  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

`default_nettype wire

@@ sv/direct_form_iir_filter.sv @@
// A sample transaction with P coefficient pairs in use runs a tap loop in which one
// shared 32x32 multiplier forms the feedforward then the feedback product of each tap
// pair, fed by the history and coefficient RAMs; SUM, SCALE, GAIN and OUT then follow.
// Input is taken again once the result is loaded; write and clear keep the block idle.
// Reset (aresetn low, synchronous): histories and coefficients read as zero, write
// position 0, filter_order 1, output_gain 1.0, no result pending.
`default_nettype none

module direct_form_iir_filter #(
    parameter int HISTORY_DEPTH = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [23:0] sample_in, [28:24] coef_index, [60:29] feedforward_coef,
    // [92:61] feedback_coef, [95:93] zero
    input  wire logic [dfiir_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] op
    input  wire logic [dfiir_pkg::OP_W-1:0]          s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [23:0] sample_out
    output logic [dfiir_pkg::M_TDATA_W-1:0]          m_tdata,
    // [0] saturated
    output logic                                     m_tuser,
    // configuration writes
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_addr,
    input  wire logic [dfiir_pkg::CFG_W-1:0]         cfg_wdata
);

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int PAIR_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CNT_W  = $clog2(2 * HISTORY_DEPTH + 1);
    localparam int TERM_W = 48;                          // widest shifted product
    localparam int ACC_W  = TERM_W + $clog2(2 * HISTORY_DEPTH);
    localparam int HIST_W = dfiir_pkg::COEF_W + dfiir_pkg::SAMPLE_W;  // {y, x}
    localparam int CPAIR_W = 2 * dfiir_pkg::COEF_W;                   // {b, a}

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dfiir_pkg::ORDER_W-1:0] filter_order_reg;
    logic [dfiir_pkg::GAIN_W-1:0]  output_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_order_reg <= dfiir_pkg::ORDER_RESET;
            output_gain_reg  <= dfiir_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dfiir_pkg::REG_FILTER_ORDER: filter_order_reg <= cfg_wdata[dfiir_pkg::ORDER_W-1:0];
                dfiir_pkg::REG_OUTPUT_GAIN:  output_gain_reg  <= cfg_wdata[dfiir_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic [dfiir_pkg::SAMPLE_W-1:0] in_sample;
    logic [dfiir_pkg::CIDX_W-1:0]   in_cidx;
    logic [dfiir_pkg::COEF_W-1:0]   in_ff;
    logic [dfiir_pkg::COEF_W-1:0]   in_fb;
    logic                           in_acc;

    assign in_sample = s_tdata[dfiir_pkg::SAMPLE_LSB +: dfiir_pkg::SAMPLE_W];
    assign in_cidx   = s_tdata[dfiir_pkg::CIDX_LSB +: dfiir_pkg::CIDX_W];
    assign in_ff     = s_tdata[dfiir_pkg::FF_LSB +: dfiir_pkg::COEF_W];
    assign in_fb     = s_tdata[dfiir_pkg::FB_LSB +: dfiir_pkg::COEF_W];
    assign in_acc    = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    dfiir_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  step_reg;       // cycle within the tap loop
    logic [PAIR_W-1:0] pairs_reg;      // tap pairs in use for this sample
    logic [IDX_W-1:0]  wp_reg;         // history write position
    logic [HISTORY_DEPTH-1:0] hist_valid_reg;
    logic [HISTORY_DEPTH-1:0] coef_valid_reg;
    logic signed [dfiir_pkg::SAMPLE_W-1:0] sample_reg;

    logic out_free;
    logic run;
    logic last_step;
    logic iss;
    logic mul_en;
    logic [IDX_W-1:0] tap_j;
    logic [IDX_W:0]   z_diff;
    logic [IDX_W-1:0] z_addr;
    logic [PAIR_W-1:0] pairs_sel;
    logic coef_wr;
    logic [IDX_W-1:0] coef_addr;

    assign s_tready  = (state_reg == dfiir_pkg::S_IDLE);
    assign out_free  = !m_tvalid || m_tready;
    assign run       = (state_reg == dfiir_pkg::S_RUN);
    assign last_step = (step_reg == CNT_W'({pairs_reg, 1'b0}));
    assign tap_j     = IDX_W'(step_reg >> 1);
    // a tap read is issued on even steps; the multiplier runs on every step but step 0
    assign iss       = run && !step_reg[0] && ((step_reg >> 1) < CNT_W'(pairs_reg));
    assign mul_en    = run && (step_reg != '0);

    // circular address h - j
    assign z_diff = {1'b0, wp_reg} - {1'b0, tap_j};
    assign z_addr = z_diff[IDX_W] ? IDX_W'(z_diff + (IDX_W+1)'(HISTORY_DEPTH))
                                  : z_diff[IDX_W-1:0];

    // order zero acts as one, order above depth is capped
    always_comb begin
        if (filter_order_reg == '0) begin
            pairs_sel = PAIR_W'(1);
        end else if (32'(filter_order_reg) > HISTORY_DEPTH) begin
            pairs_sel = PAIR_W'(HISTORY_DEPTH);
        end else begin
            pairs_sel = PAIR_W'(filter_order_reg);
        end
    end

    assign coef_wr   = in_acc && (s_tuser == dfiir_pkg::OP_COEF_WR)
                       && (32'(in_cidx) < HISTORY_DEPTH);
    assign coef_addr = IDX_W'(in_cidx);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dfiir_pkg::S_IDLE: begin
                if (in_acc && s_tuser == dfiir_pkg::OP_PROCESS) begin
                    state_next = dfiir_pkg::S_RUN;
                end
            end
            dfiir_pkg::S_RUN: begin
                if (last_step) begin
                    state_next = dfiir_pkg::S_SUM;
                end
            end
            dfiir_pkg::S_SUM:   state_next = dfiir_pkg::S_SCALE;
            dfiir_pkg::S_SCALE: state_next = dfiir_pkg::S_GAIN;
            dfiir_pkg::S_GAIN:  state_next = dfiir_pkg::S_OUT;
            dfiir_pkg::S_OUT: begin
                if (out_free) begin
                    state_next = dfiir_pkg::S_IDLE;
                end
            end
            default: state_next = dfiir_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dfiir_pkg::S_IDLE;
            step_reg       <= '0;
            wp_reg         <= '0;
            hist_valid_reg <= '0;
            coef_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (in_acc) begin
                step_reg <= '0;
            end else if (run) begin
                step_reg <= step_reg + 1'b1;
            end
            if (in_acc && s_tuser == dfiir_pkg::OP_CLEAR) begin
                hist_valid_reg <= '0;
            end
            if (coef_wr) begin
                coef_valid_reg[coef_addr] <= 1'b1;
            end
            if (state_reg == dfiir_pkg::S_GAIN) begin
                hist_valid_reg[wp_reg] <= 1'b1;
                wp_reg <= (wp_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            sample_reg <= in_sample;
            pairs_reg  <= pairs_sel;
        end
    end

    // ------------------------------------------------------------------
    // History and coefficient RAMs, registered read
    // ------------------------------------------------------------------
    logic [HIST_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic [CPAIR_W-1:0] coef_mem [HISTORY_DEPTH];
    logic [HIST_W-1:0]  hist_q_reg;
    logic [CPAIR_W-1:0] coef_q_reg;
    logic hist_ok_reg;
    logic coef_ok_reg;
    logic first_reg;                   // tap 0: x from the live sample, no feedback
    logic [dfiir_pkg::COEF_W-1:0] stored_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == dfiir_pkg::S_GAIN) begin
            hist_mem[wp_reg] <= {stored_reg, sample_reg};
        end
        if (iss) begin
            hist_q_reg  <= hist_mem[z_addr];
            hist_ok_reg <= hist_valid_reg[z_addr];
            first_reg   <= (tap_j == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_wr) begin
            coef_mem[coef_addr] <= {in_fb, in_ff};
        end
        if (iss) begin
            coef_q_reg  <= coef_mem[tap_j];
            coef_ok_reg <= coef_valid_reg[tap_j];
        end
    end

    // ------------------------------------------------------------------
    // Shared MAC: odd steps a*x >>> 15, even steps b*y >>> 16
    // ------------------------------------------------------------------
    logic signed [dfiir_pkg::COEF_W-1:0] mul_c;
    logic signed [dfiir_pkg::COEF_W-1:0] mul_d;
    logic signed [63:0]                  mul_p;
    logic signed [63:0]                  term;
    logic signed [TERM_W-1:0]            prod_reg;
    logic                                prod_vld_reg;
    logic signed [ACC_W-1:0]             acc_reg;

    always_comb begin
        if (step_reg[0]) begin
            mul_c = coef_ok_reg ? coef_q_reg[dfiir_pkg::COEF_W-1:0] : '0;
            if (first_reg) begin
                mul_d = dfiir_pkg::COEF_W'(sample_reg);
            end else if (hist_ok_reg) begin
                mul_d = dfiir_pkg::COEF_W'($signed(hist_q_reg[dfiir_pkg::SAMPLE_W-1:0]));
            end else begin
                mul_d = '0;
            end
        end else begin
            mul_c = coef_ok_reg ? coef_q_reg[CPAIR_W-1:dfiir_pkg::COEF_W] : '0;
            mul_d = (hist_ok_reg && !first_reg) ? hist_q_reg[HIST_W-1:dfiir_pkg::SAMPLE_W] : '0;
        end
    end

    assign mul_p = 64'(mul_c) * 64'(mul_d);
    assign term  = step_reg[0] ? (mul_p >>> 15) : (mul_p >>> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= TERM_W'(term);
        end
        if (in_acc) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // ------------------------------------------------------------------
    // Store saturation, output gain, output saturation
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] acc_sh;
    logic [ACC_W-32:0]       acc_top;
    logic                    acc_fits;
    logic                    stored_sat_reg;
    logic signed [63:0]      gain_prod_reg;
    logic signed [63:0]      gain_sh;
    logic [40:0]             gain_top;
    logic                    gain_fits;
    logic [dfiir_pkg::M_TDATA_W-1:0] res;

    assign acc_sh   = acc_reg >>> 8;
    assign acc_top  = acc_sh[ACC_W-1:31];
    assign acc_fits = (&acc_top) || !(|acc_top);

    assign gain_sh   = gain_prod_reg >>> 25;
    assign gain_top  = gain_sh[63:23];
    assign gain_fits = (&gain_top) || !(|gain_top);

    always_comb begin
        if (gain_fits) begin
            res = gain_sh[dfiir_pkg::M_TDATA_W-1:0];
        end else if (gain_sh[63]) begin
            res = dfiir_pkg::OUT_MIN;
        end else begin
            res = dfiir_pkg::OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == dfiir_pkg::S_SCALE) begin
            stored_sat_reg <= !acc_fits;
            if (acc_fits) begin
                stored_reg <= acc_sh[31:0];
            end else begin
                stored_reg <= acc_sh[ACC_W-1] ? dfiir_pkg::STORED_MIN : dfiir_pkg::STORED_MAX;
            end
        end
        if (state_reg == dfiir_pkg::S_GAIN) begin
            gain_prod_reg <= 64'($signed(stored_reg)) * 64'({1'b0, output_gain_reg});
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a result while the next item is taken in
    // ------------------------------------------------------------------
    logic                            m_tvalid_reg;
    logic [dfiir_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tuser_reg;
    logic                            out_load;

    assign out_load = (state_reg == dfiir_pkg::S_OUT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res;
            m_tuser_reg <= stored_sat_reg || !gain_fits;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

@@ sv/dfiir_checker.sv @@
`default_nettype none

module dfiir_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [dfiir_pkg::OP_W-1:0]      s_tuser,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dfiir_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                            m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // an accepted sample makes the block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == dfiir_pkg::OP_PROCESS |=> !s_tready)
        else $error("input accepted during sample processing");

    // write, clear and unused codes leave the block ready
    a_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != dfiir_pkg::OP_PROCESS |=> s_tready)
        else $error("block busy after single-cycle transaction");

endmodule

bind direct_form_iir_filter dfiir_checker u_dfiir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    // Items go in on the s_ stream (op on s_tuser; sample, slot and coefficient pair packed
    // in s_tdata). An in-bench filter model predicts every result at the input handshake,
    // and a checker compares each m_ transaction against the oldest prediction.
    // Register writes happen only once the block has drained.

    localparam int          HIST_DEPTH     = 32;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;      // ignored by the block
    localparam int          DRAIN_PAD      = 80;        // drain time for one full-order sample
    localparam int          WATCHDOG_LIMIT = 4000;      // cycles with no transaction at all
    localparam int          HOLD_CYCLES    = 600;       // long result-side hold-off
    localparam logic [30:0] GAIN_UNITY     = 31'd16777216;
    localparam logic [30:0] GAIN_MAX       = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [dfiir_pkg::SAMPLE_W-1:0] sample_out;
        logic                           saturated;
    } filter_result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dfiir_pkg::S_TDATA_W-1:0] s_tdata;      // sample, slot, ff coef, fb coef, zero pad
    logic [dfiir_pkg::OP_W-1:0]      s_tuser;      // op
    logic                            m_tvalid;
    logic                            m_tready;
    logic [dfiir_pkg::M_TDATA_W-1:0] m_tdata;      // sample_out
    logic                            m_tuser;      // saturated
    logic                            cfg_wr_en;
    logic                            cfg_addr;
    logic [dfiir_pkg::CFG_W-1:0]     cfg_wdata;

    // filter model state
    logic signed [23:0] x_hist  [HIST_DEPTH];
    logic signed [31:0] y_hist  [HIST_DEPTH];
    logic signed [31:0] ff_taps [HIST_DEPTH];
    logic signed [31:0] fb_taps [HIST_DEPTH];
    logic [4:0]         hist_pos;
    logic [5:0]         order_cfg;
    logic [30:0]        gain_cfg;

    filter_result_t expected_q[$];
    filter_result_t want_result;

    // run controls and tallies
    bit send_gaps;
    bit recv_gaps;
    int rx_hold_len;
    int idle_cycles;
    int error_count;
    int results_checked;
    int samples_sent;
    int coefs_sent;
    int clears_sent;
    int unused_sent;
    int cfg_writes;

    direct_form_iir_filter #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- filter model

    task automatic reset_model();
        for (int i = 0; i < HIST_DEPTH; i++) begin
            x_hist[i]  = '0;
            y_hist[i]  = '0;
            ff_taps[i] = '0;
            fb_taps[i] = '0;
        end
        hist_pos  = '0;
        order_cfg = dfiir_pkg::ORDER_RESET;
        gain_cfg  = dfiir_pkg::GAIN_RESET;
    endtask

    // Updates the model for one accepted item and queues the result a sample produces.
    task automatic filter_predict(input logic [1:0] op, input logic [23:0] sample,
                                  input logic [4:0] slot, input logic [31:0] ffc,
                                  input logic [31:0] fbc);
        longint         acc;
        longint         stored;
        longint         scaled;
        int             pairs;
        logic [4:0]     tap;
        filter_result_t res;
        case (op)
            dfiir_pkg::OP_COEF_WR: begin
                ff_taps[slot] = ffc;
                fb_taps[slot] = fbc;
            end
            dfiir_pkg::OP_CLEAR: begin
                // coefficients and write position survive a clear
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    x_hist[i] = '0;
                    y_hist[i] = '0;
                end
            end
            dfiir_pkg::OP_PROCESS: begin
                res.saturated = 1'b0;
                pairs = (order_cfg > HIST_DEPTH) ? HIST_DEPTH : order_cfg;
                x_hist[hist_pos] = sample;
                // a*x is Q.47 -> Q.32 (>>15), b*y is Q.48 -> Q.32 (>>16), floor shifts
                acc = (longint'(ff_taps[0]) * longint'($signed(sample))) >>> 15;
                // order 0 behaves like order 1: loop body never runs
                for (int j = 1; j < pairs; j++) begin
                    tap = hist_pos - 5'(j);
                    acc += (longint'(ff_taps[j]) * longint'(x_hist[tap])) >>> 15;
                    acc += (longint'(fb_taps[j]) * longint'(y_hist[tap])) >>> 16;
                end
                stored = acc >>> 8;
                if (stored > 64'sd2147483647) begin
                    stored = 64'sd2147483647;
                    res.saturated = 1'b1;
                end else if (stored < -64'sd2147483648) begin
                    stored = -64'sd2147483648;
                    res.saturated = 1'b1;
                end
                y_hist[hist_pos] = stored[31:0];
                hist_pos = hist_pos + 5'd1;
                scaled = (stored * longint'(gain_cfg)) >>> 25;
                if (scaled > 64'sd8388607) begin
                    scaled = 64'sd8388607;
                    res.saturated = 1'b1;
                end else if (scaled < -64'sd8388608) begin
                    scaled = -64'sd8388608;
                    res.saturated = 1'b1;
                end
                res.sample_out = scaled[23:0];
                expected_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [31:0] rand_signed(input int unsigned mag);
        int v;
        v = int'($urandom_range(0, 2 * mag)) - int'(mag);
        return v;
    endfunction

    function automatic logic [31:0] pick_coef(input bit wide, input int unsigned mag);
        return wide ? $urandom : rand_signed(mag);
    endfunction

    function automatic logic [23:0] next_sample();
        case ($urandom_range(0, 9))
            0:       return dfiir_pkg::OUT_MAX;
            1:       return dfiir_pkg::OUT_MIN;
            2, 3:    return 24'(rand_signed(4096));
            default: return 24'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction,
    // with s_tvalid still high so back-to-back items follow without a gap.
    task automatic send_item(input logic [1:0] op, input logic [23:0] sample,
                             input logic [4:0] slot, input logic [31:0] ffc,
                             input logic [31:0] fbc);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, fbc, ffc, slot, sample};
        do @(posedge aclk); while (s_tready !== 1'b1);
        filter_predict(op, sample, slot, ffc, fbc);
        case (op)
            dfiir_pkg::OP_PROCESS: samples_sent++;
            dfiir_pkg::OP_COEF_WR: coefs_sent++;
            dfiir_pkg::OP_CLEAR:   clears_sent++;
            default:               unused_sent++;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_sample(input logic [23:0] x);
        send_item(dfiir_pkg::OP_PROCESS, x, 5'($urandom), $urandom, $urandom);
    endtask

    task automatic send_coef(input logic [4:0] slot, input logic [31:0] a, input logic [31:0] b);
        send_item(dfiir_pkg::OP_COEF_WR, 24'($urandom), slot, a, b);
    endtask

    task automatic send_clear();
        send_item(dfiir_pkg::OP_CLEAR, 24'($urandom), 5'($urandom), $urandom, $urandom);
    endtask

    task automatic send_unused();
        send_item(OP_UNUSED, 24'($urandom), 5'($urandom), $urandom, $urandom);
    endtask

    // Stop offering, wait for every predicted result, then cover a full-order sample
    // that might still be in flight behind a write or clear.
    task automatic wait_for_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_PAD) @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [30:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        if (addr == dfiir_pkg::REG_FILTER_ORDER)
            order_cfg = value[5:0];
        else
            gain_cfg = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Fill all 32 slots: small stable taps, or full-range noise when wide.
    task automatic load_coef_set(input bit wide);
        for (int slot = 0; slot < HIST_DEPTH; slot++)
            send_coef(5'(slot), pick_coef(wide, (slot == 0) ? 2 ** 24 : 2 ** 21),
                      pick_coef(wide, 2 ** 18));
    endtask

    // ---------------------------------------------------------------- tests

    // Order 1, unity gain: op kinds, sample rails, a0 rails, both saturation points.
    task automatic test_coef_and_sample_extremes();
        send_sample(dfiir_pkg::OUT_MAX);                // all coefficients still zero
        send_unused();
        send_coef(5'd0, 32'h0100_0000, dfiir_pkg::STORED_MAX);  // a0 = 1.0
        send_sample(dfiir_pkg::OUT_MAX);
        send_sample(dfiir_pkg::OUT_MIN);
        send_sample(24'd0);
        send_coef(5'd0, dfiir_pkg::STORED_MAX, dfiir_pkg::STORED_MIN);
        send_sample(dfiir_pkg::OUT_MAX);                // output clips
        send_coef(5'd0, dfiir_pkg::STORED_MIN, 32'd0);
        send_sample(dfiir_pkg::OUT_MIN);                // stored value clips high
        send_sample(dfiir_pkg::OUT_MAX);
        send_clear();
        send_sample(24'd1);
    endtask

    // Full order, order zero (acts as one) and order above depth (capped).
    task automatic test_order_limits();
        wait_for_idle();
        write_reg(dfiir_pkg::REG_FILTER_ORDER, 31'd32);
        write_reg(dfiir_pkg::REG_OUTPUT_GAIN, GAIN_MAX);
        send_coef(5'd31, dfiir_pkg::STORED_MAX, dfiir_pkg::STORED_MIN);
        send_coef(5'd1, 32'h0080_0000, 32'hFFF0_0000);
        send_sample(dfiir_pkg::OUT_MAX);
        send_sample(dfiir_pkg::OUT_MIN);
        send_sample(24'h00_0100);
        wait_for_idle();
        write_reg(dfiir_pkg::REG_FILTER_ORDER, 31'd0);
        write_reg(dfiir_pkg::REG_OUTPUT_GAIN, 31'd0);
        send_sample(dfiir_pkg::OUT_MAX);
        wait_for_idle();
        write_reg(dfiir_pkg::REG_FILTER_ORDER, 31'd63);
        write_reg(dfiir_pkg::REG_OUTPUT_GAIN, GAIN_UNITY);
        send_sample(dfiir_pkg::OUT_MIN);
        send_sample(next_sample());
    endtask

    // Register settings per phase, a fresh coefficient set, then a mixed stream.
    task automatic test_random_phases();
        logic [30:0] order_pick;
        logic [30:0] gain_pick;
        bit          wide;
        int          n;
        int          pick;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       order_pick = 31'd32;
                1:       order_pick = 31'd1;
                2:       order_pick = 31'($urandom_range(0, 63));
                default: order_pick = 31'($urandom_range(1, 32));
            endcase
            case ($urandom_range(0, 5))
                0:       gain_pick = GAIN_MAX;
                1:       gain_pick = 31'd0;
                2:       gain_pick = 31'($urandom);
                default: gain_pick = 31'($urandom_range(2 ** 23, 2 ** 25));
            endcase
            wide = ($urandom_range(0, 3) == 0);
            wait_for_idle();
            write_reg(dfiir_pkg::REG_FILTER_ORDER, order_pick);
            write_reg(dfiir_pkg::REG_OUTPUT_GAIN, gain_pick);
            load_coef_set(wide);
            n = 0;
            while (n < 170) begin
                pick = $urandom_range(0, 99);
                if (pick < 88) begin
                    send_sample(next_sample());
                    n++;
                end else if (pick < 94) begin
                    // mid-stream retune of one slot
                    send_coef(5'($urandom), pick_coef($urandom_range(0, 4) == 0, 2 ** 21),
                              pick_coef($urandom_range(0, 4) == 0, 2 ** 18));
                    n++;
                end else if (pick < 97) begin
                    send_clear();
                    n++;
                end else begin
                    send_unused();
                end
            end
        end
    endtask

    // Result side holds off while the sender keeps offering; the input must stall.
    task automatic test_output_backpressure();
        wait_for_idle();
        write_reg(dfiir_pkg::REG_FILTER_ORDER, 31'd4);
        write_reg(dfiir_pkg::REG_OUTPUT_GAIN, GAIN_UNITY);
        rx_hold_len = HOLD_CYCLES;
        send_gaps   = 1'b0;
        repeat (60) send_sample(next_sample());
        send_gaps = 1'b1;
        wait_for_idle();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back_stream();
        wait_for_idle();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        write_reg(dfiir_pkg::REG_FILTER_ORDER, 31'($urandom_range(1, 32)));
        write_reg(dfiir_pkg::REG_OUTPUT_GAIN, GAIN_UNITY);
        repeat (200) begin
            if ($urandom_range(0, 9) == 0)
                send_coef(5'($urandom), pick_coef(1'b0, 2 ** 21), pick_coef(1'b0, 2 ** 18));
            else
                send_sample(next_sample());
        end
    endtask

    // ---------------------------------------------------------------- result side

    // Random stall bursts, or one long hold when a test asks for it.
    initial begin : result_sink
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (rx_hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_len - 1) @(negedge aclk);
                rx_hold_len = 0;
            end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 40)
            $display("%0t: %s mismatch on result %0d: got %h, expected %h",
                     $time, what, results_checked, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", 32'(m_tdata), 32'd0);
            end else begin
                want_result = expected_q.pop_front();
                if (m_tdata !== want_result.sample_out)
                    report_mismatch("sample_out", 32'(m_tdata), 32'(want_result.sample_out));
                if (m_tuser !== want_result.saturated)
                    report_mismatch("saturated", 32'(m_tuser), 32'(want_result.saturated));
            end
            results_checked++;
        end
    end

    // Hang guard: any transaction on either stream or a register write resets it.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_q.size());
            $display("direct_form_iir_filter test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = 1'b0;
        cfg_wdata       = '0;
        aresetn         = 1'b0;
        send_gaps       = 1'b1;
        recv_gaps       = 1'b1;
        rx_hold_len     = 0;
        idle_cycles     = 0;
        error_count     = 0;
        results_checked = 0;
        samples_sent    = 0;
        coefs_sent      = 0;
        clears_sent     = 0;
        unused_sent     = 0;
        cfg_writes      = 0;
        reset_model();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_coef_and_sample_extremes();
        test_order_limits();
        test_random_phases();
        test_output_backpressure();
        test_back_to_back_stream();
        wait_for_idle();

        $display("Covered %0d samples, %0d coefficient writes, %0d clears, %0d unused ops,",
                 samples_sent, coefs_sent, clears_sent, unused_sent);
        $display("%0d register writes; %0d results compared, %0d mismatches",
                 cfg_writes, results_checked, error_count);
        if (error_count == 0)
            $display("direct_form_iir_filter test passed");
        else
            $display("direct_form_iir_filter test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dfiir_pkg.sv
sv/direct_form_iir_filter.sv
sv/dfiir_checker.sv
tb/testbench.sv
